/* hdl/pdsrg_pkg.sv */
// ----------------------------------------------------------------------------
// pdsrg_pkg
// Shared types and constants of the packet driven step rate generator: the
// request and response payloads, register indexes and frame status codes.
// ----------------------------------------------------------------------------
package pdsrg_pkg;

   // Field and register widths.
   localparam int MAX_SPEED_W = 16;
   localparam int TICK_RATE_W = 24;
   localparam int TIMEOUT_W   = 30;
   localparam int CSR_DATA_W  = 30;
   localparam int CSR_INDEX_W = 2;
   localparam int POS_W       = 32;
   localparam int SPEED_W     = 32;
   localparam int OUT_AXES    = 3;
   localparam int DIV_CNT_W   = $clog2(TICK_RATE_W);

   // Register indexes on the write port.
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_SPEED = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TICK_RATE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT   = 2'd2;

   // Register reset values.
   localparam logic [MAX_SPEED_W-1:0] MAX_SPEED_RST = 16'd15000;
   localparam logic [TICK_RATE_W-1:0] TICK_RATE_RST = 24'd656250;
   localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RST   = 30'd328125000;

   // Frame format.
   localparam logic [7:0]  START_BYTE = 8'h7E;
   localparam logic [31:0] END_MARKER = 32'h7FFF_FFFF;

   // Step period after reset, before saturation to the period width.
   localparam longint unsigned RESET_PERIOD = 64'd100000;

   // Request kinds.
   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   // Frame status codes.
   localparam logic [1:0] FRAME_NONE     = 2'd0;
   localparam logic [1:0] FRAME_ACCEPTED = 2'd1;
   localparam logic [1:0] FRAME_BAD_END  = 2'd2;
   localparam logic [1:0] FRAME_DROPPED  = 2'd3;

   typedef struct packed {
      logic       req_type;
      logic [7:0] rx_byte;
   } req_data_type;

   typedef struct packed {
      logic [2:0]              step_pulses;
      logic [2:0]              direction_bits;
      logic                    drives_enabled;
      logic [2:0]              running_bits;
      logic [1:0]              frame_status;
      logic signed [POS_W-1:0] position_axis1;
      logic signed [POS_W-1:0] position_axis2;
      logic signed [POS_W-1:0] position_axis3;
   } rsp_data_type;

endpackage

/* hdl/packet_driven_step_rate_generator.sv */
// A byte request goes from idle straight to the finishing state; a tick passes through
// the tick state first. The byte that completes a good frame runs, per commanded axis,
// through prep, the bit-serial divider (one quotient bit per cycle) and write; a zero-speed axis only through prep.
// Requests are taken one at a time: none is accepted until the last response is loaded.
// Reset is synchronous; all control state and configuration registers return to their
// defaults at once, with no clearing pass.
// ----------------------------------------------------------------------------
// packet_driven_step_rate_generator
// Parses speed frames from a serial byte stream, converts each axis speed to a
// step period with a shared bit-serial divider and generates step pulses on
// timer ticks, with a watchdog that stops all axes when frames stop coming.
// ----------------------------------------------------------------------------
module packet_driven_step_rate_generator #(
   parameter int NUM_AXES      = 3,
   parameter int PAYLOAD_BYTES = 12,
   parameter int PERIOD_WIDTH  = 24
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_we,
   input  logic [pdsrg_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [pdsrg_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  pdsrg_pkg::req_data_type                 req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output pdsrg_pkg::rsp_data_type                 rsp_data
);

   localparam int PAYLOAD_W = 8 * PAYLOAD_BYTES;
   localparam int CNT_W     = $clog2(PAYLOAD_BYTES);
   localparam int CMD_AXES  = (NUM_AXES < PAYLOAD_BYTES / 4) ? NUM_AXES : PAYLOAD_BYTES / 4;
   localparam int AXIS_W    = (CMD_AXES > 1) ? $clog2(CMD_AXES) : 1;
   localparam int QUO_EXT_W = (PERIOD_WIDTH > pdsrg_pkg::TICK_RATE_W) ?
                              PERIOD_WIDTH : pdsrg_pkg::TICK_RATE_W;
   localparam longint unsigned PERIOD_MAX_L = (64'd1 << PERIOD_WIDTH) - 64'd1;
   localparam longint unsigned RESET_PER_L  = (pdsrg_pkg::RESET_PERIOD > PERIOD_MAX_L) ?
                                              PERIOD_MAX_L : pdsrg_pkg::RESET_PERIOD;
   localparam logic [PERIOD_WIDTH-1:0] RESET_PER = PERIOD_WIDTH'(RESET_PER_L);
   localparam logic [QUO_EXT_W-1:0]    PER_MAX_EXT = QUO_EXT_W'(PERIOD_MAX_L);
   localparam logic [pdsrg_pkg::TIMEOUT_W-1:0] ELAPSED_MAX = '1;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_TICK   = 6'b000010,
      ST_PREP   = 6'b000100,
      ST_DIV    = 6'b001000,
      ST_WRITE  = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   typedef enum logic [2:0] {
      PH_WAIT = 3'b001,
      PH_LOAD = 3'b010,
      PH_END  = 3'b100
   } phase_type;

   // Configuration registers.
   logic [pdsrg_pkg::MAX_SPEED_W-1:0] max_speed_ff, max_speed_in;
   logic [pdsrg_pkg::TICK_RATE_W-1:0] tick_rate_ff, tick_rate_in;
   logic [pdsrg_pkg::TIMEOUT_W-1:0]   timeout_ff, timeout_in;

   // Control and parser state.
   state_type                state_ff, state_in;
   phase_type                phase_ff, phase_in;
   logic [CNT_W-1:0]         byte_cnt_ff, byte_cnt_in;
   logic                     end_ok_ff, end_ok_in;
   logic [PAYLOAD_W-1:0]     payload_ff, payload_in;

   // Axis state.
   logic [pdsrg_pkg::POS_W-1:0] pos_ff [NUM_AXES];
   logic [pdsrg_pkg::POS_W-1:0] pos_in [NUM_AXES];
   logic [PERIOD_WIDTH-1:0]     period_ff [NUM_AXES];
   logic [PERIOD_WIDTH-1:0]     period_in [NUM_AXES];
   logic [PERIOD_WIDTH-1:0]     count_ff [NUM_AXES];
   logic [PERIOD_WIDTH-1:0]     count_in [NUM_AXES];
   logic [PERIOD_WIDTH-1:0]     count_inc [NUM_AXES];
   logic [NUM_AXES-1:0]         move_ff, move_in;
   logic [NUM_AXES-1:0]         fwd_ff, fwd_in;
   logic [NUM_AXES-1:0]         run_ff, run_in;
   logic                        drive_ff, drive_in;
   logic [pdsrg_pkg::TIMEOUT_W-1:0] elapsed_ff, elapsed_in;

   // Result being assembled.
   logic [1:0]               status_ff, status_in;
   logic [NUM_AXES-1:0]      pulses_ff, pulses_in;

   // Command sequencing and bit-serial divider.
   logic [AXIS_W-1:0]                  axis_idx_ff, axis_idx_in;
   logic [pdsrg_pkg::MAX_SPEED_W-1:0]  divisor_ff, divisor_in;
   logic [pdsrg_pkg::MAX_SPEED_W-1:0]  rem_ff, rem_in;
   logic [pdsrg_pkg::TICK_RATE_W-1:0]  quo_ff, quo_in;
   logic [pdsrg_pkg::DIV_CNT_W-1:0]    div_cnt_ff, div_cnt_in;

   // Response register.
   logic                     rsp_valid_ff, rsp_valid_in;
   pdsrg_pkg::rsp_data_type  rsp_data_ff, rsp_data_in;

   // Helpers.
   logic                     req_fire;
   logic                     rsp_load;
   logic [1:0]               exp_sel;
   logic [7:0]               end_expect;
   logic                     end_match;
   logic [pdsrg_pkg::TIMEOUT_W-1:0] elapsed_inc;
   logic [pdsrg_pkg::SPEED_W-1:0]   raw_speed;
   logic [pdsrg_pkg::SPEED_W-1:0]   raw_mag;
   logic                     raw_neg;
   logic                     raw_nz;
   logic [pdsrg_pkg::MAX_SPEED_W-1:0] speed_lim;
   logic [pdsrg_pkg::MAX_SPEED_W-1:0] cmd_divisor;
   logic [pdsrg_pkg::MAX_SPEED_W:0]   div_trial;
   logic [pdsrg_pkg::MAX_SPEED_W:0]   div_diff;
   logic                     q_bit;
   logic [QUO_EXT_W-1:0]     quo_ext;
   logic [PERIOD_WIDTH-1:0]  period_sat;
   logic                     last_axis;
   logic [2:0]               out_dir;
   logic [2:0]               out_run;
   logic [2:0]               out_pulse;
   logic [pdsrg_pkg::POS_W-1:0] out_pos [pdsrg_pkg::OUT_AXES];

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_load  = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   // End marker byte expected at the current position.
   assign exp_sel    = 2'd3 - byte_cnt_ff[1:0];
   assign end_expect = 8'(pdsrg_pkg::END_MARKER >> {exp_sel, 3'b000});
   assign end_match  = (req_data.rx_byte == end_expect);

   // Watchdog count, saturating.
   assign elapsed_inc = (elapsed_ff == ELAPSED_MAX) ? elapsed_ff : elapsed_ff + 1'b1;

   // Speed of the axis being commanded sits in the top word of the payload.
   assign raw_speed   = payload_ff[PAYLOAD_W-1 -: pdsrg_pkg::SPEED_W];
   assign raw_neg     = raw_speed[pdsrg_pkg::SPEED_W-1];
   assign raw_nz      = |raw_speed;
   assign raw_mag     = raw_neg ? (pdsrg_pkg::SPEED_W'(0) - raw_speed) : raw_speed;
   assign speed_lim   = (max_speed_ff == '0) ? pdsrg_pkg::MAX_SPEED_W'(1) : max_speed_ff;
   assign cmd_divisor = (raw_mag > pdsrg_pkg::SPEED_W'(speed_lim)) ?
                        speed_lim : raw_mag[pdsrg_pkg::MAX_SPEED_W-1:0];

   // One restoring division step: the remainder stays below the divisor.
   assign div_trial = {rem_ff, quo_ff[pdsrg_pkg::TICK_RATE_W-1]};
   assign div_diff  = div_trial - {1'b0, divisor_ff};
   assign q_bit     = !div_diff[pdsrg_pkg::MAX_SPEED_W];

   // Quotient saturated to the period width.
   assign quo_ext    = QUO_EXT_W'(quo_ff);
   assign period_sat = PERIOD_WIDTH'((quo_ext > PER_MAX_EXT) ? PER_MAX_EXT : quo_ext);

   assign last_axis = (axis_idx_ff == AXIS_W'(CMD_AXES - 1));

   // Per-axis tick counter increment, wrapping at the period width.
   for (genvar g = 0; g < NUM_AXES; g++) begin : g_inc
      assign count_inc[g] = count_ff[g] + 1'b1;
   end

   // Axes shown in the response; missing axes read as zero.
   for (genvar g = 0; g < pdsrg_pkg::OUT_AXES; g++) begin : g_out
      if (g < NUM_AXES) begin : g_have
         assign out_dir[g]   = move_ff[g] & fwd_ff[g];
         assign out_run[g]   = run_ff[g];
         assign out_pulse[g] = pulses_ff[g];
         assign out_pos[g]   = pos_ff[g];
      end else begin : g_none
         assign out_dir[g]   = 1'b0;
         assign out_run[g]   = 1'b0;
         assign out_pulse[g] = 1'b0;
         assign out_pos[g]   = '0;
      end
   end

   // Configuration writes.
   always_comb begin
      max_speed_in = max_speed_ff;
      tick_rate_in = tick_rate_ff;
      timeout_in   = timeout_ff;
      if (csr_we) begin
         case (csr_index)
            pdsrg_pkg::CSR_MAX_SPEED: begin
               max_speed_in = csr_wdata[pdsrg_pkg::MAX_SPEED_W-1:0];
            end
            pdsrg_pkg::CSR_TICK_RATE: begin
               tick_rate_in = csr_wdata[pdsrg_pkg::TICK_RATE_W-1:0];
            end
            pdsrg_pkg::CSR_TIMEOUT: begin
               timeout_in = csr_wdata[pdsrg_pkg::TIMEOUT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Main sequencer: parser, tick processing, axis command and divider.
   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      byte_cnt_in = byte_cnt_ff;
      end_ok_in   = end_ok_ff;
      payload_in  = payload_ff;
      pos_in      = pos_ff;
      period_in   = period_ff;
      count_in    = count_ff;
      move_in     = move_ff;
      fwd_in      = fwd_ff;
      run_in      = run_ff;
      drive_in    = drive_ff;
      elapsed_in  = elapsed_ff;
      status_in   = status_ff;
      pulses_in   = pulses_ff;
      axis_idx_in = axis_idx_ff;
      divisor_in  = divisor_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      div_cnt_in  = div_cnt_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_data.req_type == pdsrg_pkg::REQ_TICK) begin
               // Watchdog first; a timeout stops every axis before counting.
               status_in  = pdsrg_pkg::FRAME_NONE;
               elapsed_in = elapsed_inc;
               if (elapsed_inc > timeout_ff) begin
                  run_in   = '0;
                  drive_in = 1'b0;
               end
               state_in = ST_TICK;
            end else if (req_fire) begin
               status_in = pdsrg_pkg::FRAME_NONE;
               pulses_in = '0;
               state_in  = ST_FINISH;
               case (phase_ff)
                  PH_LOAD: begin
                     payload_in = {payload_ff[PAYLOAD_W-9:0], req_data.rx_byte};
                     if (byte_cnt_ff == CNT_W'(PAYLOAD_BYTES - 1)) begin
                        phase_in    = PH_END;
                        byte_cnt_in = '0;
                        end_ok_in   = 1'b1;
                     end else begin
                        byte_cnt_in = byte_cnt_ff + 1'b1;
                     end
                  end
                  PH_END: begin
                     end_ok_in = end_ok_ff & end_match;
                     if (byte_cnt_ff == CNT_W'(3)) begin
                        phase_in    = PH_WAIT;
                        byte_cnt_in = '0;
                        if (end_ok_ff & end_match) begin
                           // Good frame: command the axes one after another.
                           status_in   = pdsrg_pkg::FRAME_ACCEPTED;
                           drive_in    = 1'b1;
                           elapsed_in  = '0;
                           axis_idx_in = '0;
                           state_in    = ST_PREP;
                        end else begin
                           status_in = pdsrg_pkg::FRAME_BAD_END;
                        end
                     end else begin
                        byte_cnt_in = byte_cnt_ff + 1'b1;
                     end
                  end
                  default: begin
                     byte_cnt_in = '0;
                     if (req_data.rx_byte == pdsrg_pkg::START_BYTE) begin
                        phase_in = PH_LOAD;
                     end else begin
                        phase_in  = PH_WAIT;
                        status_in = pdsrg_pkg::FRAME_DROPPED;
                     end
                  end
               endcase
            end
         end

         ST_TICK: begin
            // Every running axis counts; reaching the period gives a step.
            pulses_in = '0;
            for (int k = 0; k < NUM_AXES; k++) begin
               if (run_ff[k]) begin
                  if (count_inc[k] >= period_ff[k]) begin
                     count_in[k]  = '0;
                     pulses_in[k] = 1'b1;
                     if (move_ff[k]) begin
                        pos_in[k] = fwd_ff[k] ? pos_ff[k] + 1'b1 : pos_ff[k] - 1'b1;
                     end
                  end else begin
                     count_in[k] = count_inc[k];
                  end
               end
            end
            state_in = ST_FINISH;
         end

         ST_PREP: begin
            // Direction is recorded for every commanded axis.
            for (int k = 0; k < NUM_AXES; k++) begin
               if (k < CMD_AXES && axis_idx_ff == AXIS_W'(k)) begin
                  move_in[k] = 1'b1;
                  fwd_in[k]  = !raw_neg && raw_nz;
                  if (!raw_nz) begin
                     run_in[k] = 1'b0;
                  end
               end
            end
            if (raw_nz) begin
               divisor_in = cmd_divisor;
               rem_in     = '0;
               quo_in     = tick_rate_ff;
               div_cnt_in = '0;
               state_in   = ST_DIV;
            end else begin
               payload_in = payload_ff << pdsrg_pkg::SPEED_W;
               if (last_axis) begin
                  state_in = ST_FINISH;
               end else begin
                  axis_idx_in = axis_idx_ff + 1'b1;
                  state_in    = ST_PREP;
               end
            end
         end

         ST_DIV: begin
            // One quotient bit per cycle, dividend bits shifting out on top.
            rem_in     = q_bit ? div_diff[pdsrg_pkg::MAX_SPEED_W-1:0] :
                                 div_trial[pdsrg_pkg::MAX_SPEED_W-1:0];
            quo_in     = {quo_ff[pdsrg_pkg::TICK_RATE_W-2:0], q_bit};
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == pdsrg_pkg::DIV_CNT_W'(pdsrg_pkg::TICK_RATE_W - 1)) begin
               state_in = ST_WRITE;
            end
         end

         ST_WRITE: begin
            for (int k = 0; k < NUM_AXES; k++) begin
               if (k < CMD_AXES && axis_idx_ff == AXIS_W'(k)) begin
                  period_in[k] = period_sat;
                  count_in[k]  = '0;
                  run_in[k]    = 1'b1;
               end
            end
            payload_in = payload_ff << pdsrg_pkg::SPEED_W;
            if (last_axis) begin
               state_in = ST_FINISH;
            end else begin
               axis_idx_in = axis_idx_ff + 1'b1;
               state_in    = ST_PREP;
            end
         end

         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response register: holds a finished request until it is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.step_pulses    = out_pulse;
         rsp_data_in.direction_bits = out_dir;
         rsp_data_in.drives_enabled = drive_ff;
         rsp_data_in.running_bits   = out_run;
         rsp_data_in.frame_status   = status_ff;
         rsp_data_in.position_axis1 = out_pos[0];
         rsp_data_in.position_axis2 = out_pos[1];
         rsp_data_in.position_axis3 = out_pos[2];
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_speed_ff <= pdsrg_pkg::MAX_SPEED_RST;
         tick_rate_ff <= pdsrg_pkg::TICK_RATE_RST;
         timeout_ff   <= pdsrg_pkg::TIMEOUT_RST;
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_WAIT;
         byte_cnt_ff  <= '0;
         end_ok_ff    <= 1'b1;
         for (int k = 0; k < NUM_AXES; k++) begin
            pos_ff[k]    <= '0;
            period_ff[k] <= RESET_PER;
            count_ff[k]  <= '0;
         end
         move_ff      <= '0;
         fwd_ff       <= '0;
         run_ff       <= '1;
         drive_ff     <= 1'b1;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         max_speed_ff <= max_speed_in;
         tick_rate_ff <= tick_rate_in;
         timeout_ff   <= timeout_in;
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         byte_cnt_ff  <= byte_cnt_in;
         end_ok_ff    <= end_ok_in;
         pos_ff       <= pos_in;
         period_ff    <= period_in;
         count_ff     <= count_in;
         move_ff      <= move_in;
         fwd_ff       <= fwd_in;
         run_ff       <= run_in;
         drive_ff     <= drive_in;
         elapsed_ff   <= elapsed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers without reset.
   always_ff @(posedge clock) begin
      payload_ff  <= payload_in;
      status_ff   <= status_in;
      pulses_ff   <= pulses_in;
      axis_idx_ff <= axis_idx_in;
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      div_cnt_ff  <= div_cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   // A response only appears out of the finishing state.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside the finishing state");

   // With the drives disabled no axis may run.
   a_stop_on_disable: assert property (@(posedge clock) disable iff (reset)
      !drive_ff |-> (run_ff == '0))
      else $error("axis running while drives are disabled");

   // An accepted frame always reports enabled drives.
   a_accept_enables: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.frame_status == pdsrg_pkg::FRAME_ACCEPTED)
      |-> rsp_data_ff.drives_enabled)
      else $error("accepted frame without enabled drives");

   // Step pulses only come with tick responses, which carry no frame status.
   a_pulse_no_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.step_pulses != 3'd0)
      |-> (rsp_data_ff.frame_status == pdsrg_pkg::FRAME_NONE))
      else $error("step pulses reported with a frame status");
`endif

endmodule

/* bench/pdsrg_checker.sv */
// ----------------------------------------------------------------------------
// pdsrg_checker
// Watches the request, response and register ports of the step rate
// generator. Each accepted request is run through a cycle-free model of the
// frame parser, the period divider and the step timers, and the response it
// implies is queued. Each accepted response is compared field by field with
// the oldest queued one. Mismatches and the number still due go to the top.
// ----------------------------------------------------------------------------
module pdsrg_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [pdsrg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pdsrg_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  pdsrg_pkg::req_data_type           req_data,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  pdsrg_pkg::rsp_data_type           rsp_data,
   output int                                fail_count,
   output int                                due_count,
   output int                                checked_count,
   output int                                frames_accepted
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_AXES      = 3;
   localparam int PAYLOAD_LEN = 12;
   localparam int PERIOD_W    = 24;
   localparam logic [pdsrg_pkg::TIMEOUT_W-1:0] ELAPSED_SAT = '1;
   localparam logic [PERIOD_W-1:0]             PERIOD_SAT  = '1;

   typedef enum logic [1:0] {PARSE_WAIT, PARSE_LOAD, PARSE_END} parse_phase_type;
   typedef enum logic [1:0] {DIR_NONE, DIR_FWD, DIR_REV} step_dir_type;

   // Register copies.
   logic [pdsrg_pkg::MAX_SPEED_W-1:0] cfg_max_speed;
   logic [pdsrg_pkg::TICK_RATE_W-1:0] cfg_tick_rate;
   logic [pdsrg_pkg::TIMEOUT_W-1:0]   cfg_timeout;

   // Parser and axis state.
   parse_phase_type                 phase;
   int unsigned                     byte_cnt;
   logic [7:0]                      payload [PAYLOAD_LEN];
   logic                            marker_ok;
   logic [pdsrg_pkg::POS_W-1:0]     position [N_AXES];
   step_dir_type                    direction [N_AXES];
   logic                            running [N_AXES];
   logic [PERIOD_W-1:0]             period [N_AXES];
   logic [PERIOD_W-1:0]             counter [N_AXES];
   logic                            drive_on;
   logic [pdsrg_pkg::TIMEOUT_W-1:0] elapsed;

   pdsrg_pkg::rsp_data_type         due_responses [$];

   // Advances the model by one request and returns the response it implies.
   function automatic pdsrg_pkg::rsp_data_type step_generator_response(
      input pdsrg_pkg::req_data_type r);
      pdsrg_pkg::rsp_data_type res;
      logic [2:0]   pulses;
      logic [1:0]   status;
      logic [31:0]  raw;
      logic [31:0]  mag;
      logic [31:0]  lim;
      logic [7:0]   marker_byte;
      int           base;
      pulses = '0;
      status = pdsrg_pkg::FRAME_NONE;
      if (r.req_type == pdsrg_pkg::REQ_TICK) begin
         // Watchdog first, then the step timers of the axes still running.
         if (elapsed < ELAPSED_SAT) elapsed = elapsed + 1'b1;
         if (elapsed > cfg_timeout) begin
            for (int k = 0; k < N_AXES; k++) running[k] = 1'b0;
            drive_on = 1'b0;
         end
         for (int k = 0; k < N_AXES; k++) begin
            if (running[k]) begin
               counter[k] = counter[k] + 1'b1;
               if (counter[k] >= period[k]) begin
                  counter[k] = '0;
                  if (direction[k] == DIR_FWD) position[k] = position[k] + 1'b1;
                  else if (direction[k] == DIR_REV) position[k] = position[k] - 1'b1;
                  pulses[k] = 1'b1;
               end
            end
         end
      end else begin
         case (phase)
            PARSE_LOAD: begin
               payload[byte_cnt] = r.rx_byte;
               byte_cnt++;
               if (byte_cnt >= PAYLOAD_LEN) begin
                  phase = PARSE_END;
                  byte_cnt = 0;
                  marker_ok = 1'b1;
               end
            end
            PARSE_END: begin
               marker_byte = 8'(pdsrg_pkg::END_MARKER >> (8 * (3 - byte_cnt)));
               if (r.rx_byte != marker_byte) marker_ok = 1'b0;
               byte_cnt++;
               if (byte_cnt >= 4) begin
                  phase = PARSE_WAIT;
                  byte_cnt = 0;
                  if (marker_ok) begin
                     // Accepted frame: each axis takes its big-endian speed.
                     for (int k = 0; k < N_AXES; k++) begin
                        base = 4 * k;
                        if (base + 3 < PAYLOAD_LEN) begin
                           raw = {payload[base], payload[base + 1],
                                  payload[base + 2], payload[base + 3]};
                           direction[k] = (!raw[31] && raw != 0) ? DIR_FWD : DIR_REV;
                           mag = raw[31] ? (32'd0 - raw) : raw;
                           if (mag == 0) begin
                              running[k] = 1'b0;
                           end else begin
                              lim = (cfg_max_speed == 0) ? 32'd1 : 32'(cfg_max_speed);
                              if (mag > lim) mag = lim;
                              mag = 32'(cfg_tick_rate) / mag;
                              period[k] = (mag > 32'(PERIOD_SAT)) ? PERIOD_SAT
                                                                  : mag[PERIOD_W-1:0];
                              counter[k] = '0;
                              running[k] = 1'b1;
                           end
                        end
                     end
                     drive_on = 1'b1;
                     elapsed = '0;
                     status = pdsrg_pkg::FRAME_ACCEPTED;
                  end else begin
                     status = pdsrg_pkg::FRAME_BAD_END;
                  end
               end
            end
            default: begin
               byte_cnt = 0;
               if (r.rx_byte == pdsrg_pkg::START_BYTE) begin
                  phase = PARSE_LOAD;
               end else begin
                  phase = PARSE_WAIT;
                  status = pdsrg_pkg::FRAME_DROPPED;
               end
            end
         endcase
      end

      res.step_pulses = pulses;
      for (int k = 0; k < N_AXES; k++) begin
         res.direction_bits[k] = (direction[k] == DIR_FWD);
         res.running_bits[k]   = running[k];
      end
      res.drives_enabled = drive_on;
      res.frame_status   = status;
      res.position_axis1 = position[0];
      res.position_axis2 = position[1];
      res.position_axis3 = position[2];
      return res;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0h, actual %0h", name, want_v, got_v);
         fail_count++;
      end
   endtask

   // All ports are sampled at the rising edge, before the block updates them.
   always @(posedge clock) begin : monitor
      pdsrg_pkg::rsp_data_type want;
      if (reset) begin
         cfg_max_speed = pdsrg_pkg::MAX_SPEED_RST;
         cfg_tick_rate = pdsrg_pkg::TICK_RATE_RST;
         cfg_timeout   = pdsrg_pkg::TIMEOUT_RST;
         phase         = PARSE_WAIT;
         byte_cnt      = 0;
         marker_ok     = 1'b1;
         for (int k = 0; k < N_AXES; k++) begin
            position[k]  = '0;
            direction[k] = DIR_NONE;
            running[k]   = 1'b1;
            period[k]    = (pdsrg_pkg::RESET_PERIOD > PERIOD_SAT) ? PERIOD_SAT
                                                                   : PERIOD_W'(pdsrg_pkg::RESET_PERIOD);
            counter[k]   = '0;
         end
         drive_on        = 1'b1;
         elapsed         = '0;
         fail_count      = 0;
         checked_count   = 0;
         frames_accepted = 0;
         due_responses.delete();
      end else begin
         // The user keeps register writes to an idle block; not enforced.
         if (csr_we) begin
            case (csr_index)
               pdsrg_pkg::CSR_MAX_SPEED:
                  cfg_max_speed = csr_wdata[pdsrg_pkg::MAX_SPEED_W-1:0];
               pdsrg_pkg::CSR_TICK_RATE:
                  cfg_tick_rate = csr_wdata[pdsrg_pkg::TICK_RATE_W-1:0];
               pdsrg_pkg::CSR_TIMEOUT:
                  cfg_timeout   = csr_wdata[pdsrg_pkg::TIMEOUT_W-1:0];
               default: ;
            endcase
         end

         // Compare a delivered response with the oldest one due.
         if (rsp_valid && !rsp_stall) begin
            if (due_responses.size() == 0) begin
               $error("response delivered with no request outstanding");
               fail_count++;
            end else begin
               want = due_responses.pop_front();
               check_field("step_pulses", 32'(want.step_pulses), 32'(rsp_data.step_pulses));
               check_field("direction_bits", 32'(want.direction_bits),
                           32'(rsp_data.direction_bits));
               check_field("drives_enabled", 32'(want.drives_enabled),
                           32'(rsp_data.drives_enabled));
               check_field("running_bits", 32'(want.running_bits),
                           32'(rsp_data.running_bits));
               check_field("frame_status", 32'(want.frame_status),
                           32'(rsp_data.frame_status));
               check_field("position_axis1", want.position_axis1, rsp_data.position_axis1);
               check_field("position_axis2", want.position_axis2, rsp_data.position_axis2);
               check_field("position_axis3", want.position_axis3, rsp_data.position_axis3);
               checked_count++;
            end
         end

         // Predict the response of an accepted request.
         if (req_valid && !req_stall) begin
            want = step_generator_response(req_data);
            if (want.frame_status == pdsrg_pkg::FRAME_ACCEPTED) frames_accepted++;
            due_responses.push_back(want);
         end
      end
      due_count = due_responses.size();
   end

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the packet driven step rate generator. Sends a
// short directed sequence, then random frames, broken frames, stray bytes and
// tick bursts under several register settings, with random idling on both
// channels, a long response hold-off and a full drain. The checker beside the
// block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 100;
   localparam int STALL_LIMIT   = 5000;
   localparam int IDLE_PCT      = 7;
   localparam int HOLD_CYCLES   = 300;
   localparam logic [pdsrg_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   logic                              clock;
   logic                              reset;
   logic                              csr_we;
   logic [pdsrg_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [pdsrg_pkg::CSR_DATA_W-1:0]  csr_wdata;
   logic                              req_valid;
   logic                              req_stall;
   pdsrg_pkg::req_data_type           req_data;
   logic                              rsp_valid;
   logic                              rsp_stall;
   pdsrg_pkg::rsp_data_type           rsp_data;

   int fail_count;
   int due_count;
   int checked_count;
   int frames_accepted;

   bit hold_rsp_req;
   bit quiet;
   int requests_sent;
   int settings_used;

   packet_driven_step_rate_generator i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   pdsrg_checker i_check (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .fail_count      (fail_count),
      .due_count       (due_count),
      .checked_count   (checked_count),
      .frames_accepted (frames_accepted)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Response side: random stalls, a long hold-off on request, none when quiet.
   initial begin : rsp_backpressure
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_rsp_req) begin
            hold_rsp_req = 1'b0;
            hold_left = HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else if (quiet) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // The run ends in failure if no handshake completes for too long.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("tb_top NOT OK");
      $finish;
   end

   // Offers one request, possibly after a short idle gap, and waits for it to go.
   task automatic send_request(input logic kind, input logic [7:0] b);
      pdsrg_pkg::req_data_type d;
      d.req_type = kind;
      d.rx_byte  = b;
      if (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
      @(negedge clock);
   endtask

   // Start byte, three big-endian speeds and the end marker, optionally corrupted.
   task automatic send_frame(input logic [31:0] s1, input logic [31:0] s2,
                             input logic [31:0] s3, input bit bad_end);
      logic [95:0] speeds;
      logic [31:0] marker;
      int          i;
      speeds = {s1, s2, s3};
      marker = pdsrg_pkg::END_MARKER;
      if (bad_end) begin
         i = $urandom_range(3);
         marker = marker ^ (32'($urandom_range(255, 1)) << (8 * i));
      end
      send_request(pdsrg_pkg::REQ_BYTE, pdsrg_pkg::START_BYTE);
      for (i = 0; i < 12; i++) send_request(pdsrg_pkg::REQ_BYTE, speeds[95 - 8 * i -: 8]);
      for (i = 0; i < 4; i++) send_request(pdsrg_pkg::REQ_BYTE, marker[31 - 8 * i -: 8]);
   endtask

   // Stops offering until every response is in, then waits further as its argument asks.
   task automatic wait_for_responses(input int extra);
      req_valid <= 1'b0;
      while (due_count != 0) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   task automatic write_csr(input logic [pdsrg_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [pdsrg_pkg::CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   // Writes every register, plus the unused index, which must change nothing.
   task automatic set_regs(input logic [pdsrg_pkg::MAX_SPEED_W-1:0] max_speed,
                           input logic [pdsrg_pkg::TICK_RATE_W-1:0] tick_rate,
                           input logic [pdsrg_pkg::TIMEOUT_W-1:0] timeout_ticks);
      write_csr(pdsrg_pkg::CSR_MAX_SPEED, pdsrg_pkg::CSR_DATA_W'(max_speed));
      write_csr(pdsrg_pkg::CSR_TICK_RATE, pdsrg_pkg::CSR_DATA_W'(tick_rate));
      write_csr(pdsrg_pkg::CSR_TIMEOUT, pdsrg_pkg::CSR_DATA_W'(timeout_ticks));
      write_csr(CSR_UNUSED, pdsrg_pkg::CSR_DATA_W'($urandom));
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // Mostly well-formed frames with random speeds, mixed with ticks, stray bytes
   // and frames with a broken end marker.
   task automatic run_random_phase(input int n);
      logic [31:0] sp [3];
      int          start;
      int          r;
      int          k;
      int          cnt;
      start = requests_sent;
      while (requests_sent - start < n) begin
         r = $urandom_range(99);
         if (r < 65) begin
            for (k = 0; k < 3; k++) begin
               case ($urandom_range(5))
                  0: sp[k] = 32'd0;
                  1: sp[k] = $urandom_range(64, 1);
                  2: sp[k] = 32'd0 - $urandom_range(64, 1);
                  3: sp[k] = $urandom;
                  4: sp[k] = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                  default: sp[k] = 32'd0 - $urandom_range(70000);
               endcase
            end
            send_frame(sp[0], sp[1], sp[2], r >= 55);
         end else if (r < 75) begin
            cnt = $urandom_range(3, 1);
            repeat (cnt) send_request(pdsrg_pkg::REQ_BYTE, 8'($urandom));
         end else begin
            cnt = $urandom_range(40, 1);
            repeat (cnt) send_request(pdsrg_pkg::REQ_TICK, 8'($urandom));
         end
      end
   endtask

   initial begin : stimulus
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      req_valid     = 1'b0;
      req_data      = '0;
      hold_rsp_req  = 1'b0;
      quiet         = 1'b0;
      requests_sent = 0;
      settings_used = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: stray bytes, ticks at reset values, and a frame carrying the
      // largest positive speed, the most negative speed and a zero speed.
      send_request(pdsrg_pkg::REQ_BYTE, 8'h00);
      send_request(pdsrg_pkg::REQ_BYTE, 8'hFF);
      send_request(pdsrg_pkg::REQ_TICK, 8'h5A);
      send_request(pdsrg_pkg::REQ_TICK, 8'hA5);
      send_frame(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b0);
      repeat (3) send_request(pdsrg_pkg::REQ_TICK, 8'h00);
      wait_for_responses(SETTLE_CYCLES);

      // Zero speed limit and zero tick rate: every axis commanded to a nonzero speed under them steps per tick.
      set_regs('0, '0, '1);
      run_random_phase(90);
      wait_for_responses(SETTLE_CYCLES);

      // Largest limits and a short timeout, with a long response hold-off.
      set_regs('1, '1, 30'd25);
      hold_rsp_req = 1'b1;
      run_random_phase(90);
      wait_for_responses(SETTLE_CYCLES);

      // Short periods, no idling, and a full drain in the middle.
      set_regs(16'd3, 24'd40, 30'd60);
      quiet = 1'b1;
      run_random_phase(45);
      wait_for_responses(1);
      run_random_phase(45);
      quiet = 1'b0;
      wait_for_responses(SETTLE_CYCLES);

      set_regs(16'($urandom_range(16, 1)), 24'($urandom_range(100)),
               30'($urandom_range(200, 10)));
      run_random_phase(90);
      wait_for_responses(SETTLE_CYCLES);

      // Timeout of zero: every tick stops all axes until the next good frame.
      set_regs(pdsrg_pkg::MAX_SPEED_RST, 24'd500, '0);
      run_random_phase(90);
      wait_for_responses(SETTLE_CYCLES);

      set_regs(16'($urandom), 24'($urandom_range(3000)), 30'($urandom));
      run_random_phase(40);
      wait_for_responses(SETTLE_CYCLES);

      $display("Sent %0d requests under reset values and %0d register settings.",
               requests_sent, settings_used);
      $display("Checked %0d responses; %0d frames were accepted.",
               checked_count, frames_accepted);
      if (fail_count == 0 && due_count == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
